@@ sv/sfr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the stream find-and-replace block.
// No dependencies; imported by the core, the compare unit, the output register and the testbench.
package sfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int WIN_DEPTH       = 8;
  localparam int WIN_IDX_W       = $clog2(WIN_DEPTH);

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES     = 2'd0,
    CFG_PATTERN_LENGTH    = 2'd1,
    CFG_REPLACEMENT_BYTES = 2'd2,
    CFG_REPLACEMENT_LEN   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REPL,
    ST_FLUSH,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic is_prefix;
    logic is_match;
  } cmp_status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } result_t;

  function automatic logic [3:0] eff_pattern_len(input logic [3:0] len);
    if (len == 4'd0) return 4'd1;
    if (len > 4'(MAX_PATTERN)) return 4'(MAX_PATTERN);
    return len;
  endfunction

  function automatic logic [3:0] eff_repl_len(input logic [3:0] len);
    if (len > 4'(MAX_REPLACEMENT)) return 4'(MAX_REPLACEMENT);
    return len;
  endfunction

endpackage

@@ sv/sfr_prefix_unit.sv @@
`timescale 1ns / 1ps
// Shared compare unit: checks the held window against the pattern head.
// Depends on sfr_pkg.
module sfr_prefix_unit (
  input  sfr_pkg::win_t        win,
  input  logic [3:0]           count,
  input  logic [63:0]          pattern,
  input  logic [3:0]           plen,
  output sfr_pkg::cmp_status_t status
);
  import sfr_pkg::*;

  logic ok;

  always_comb begin
    ok = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((4'(i) < count) && (win[i] != pattern[i*8 +: 8])) begin
        ok = 1'b0;
      end
    end
    status.is_prefix = ok;
    status.is_match  = ok && (count == plen);
  end

endmodule

@@ sv/sfr_out_reg.sv @@
`timescale 1ns / 1ps
// Output register for result items; frees the sequencer from the receiver.
// Depends on sfr_pkg.
module sfr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfr_pkg::result_t item,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,  // out_byte
  output logic             m_tlast,  // run_last
  output logic [1:0]       m_tuser   // [0] byte_valid, [1] string_end
);
  import sfr_pkg::*;

  result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      held <= item;
    end
  end

  assign m_tdata = held.data;
  assign m_tlast = held.run_last;
  assign m_tuser = {held.string_end, held.byte_valid};

endmodule

@@ sv/stream_find_and_replace_core.sv @@
`timescale 1ns / 1ps
// Streaming find-and-replace over a byte string, top level.
// Depends on sfr_pkg, sfr_prefix_unit, sfr_out_reg.
//
// Usage:
//   s_* takes one string byte per item (tdata = data_byte, tlast = final byte).
//   m_* gives rewritten bytes (tdata = out_byte, tlast = last result of the
//   input item, tuser[0] = byte_valid, tuser[1] = end of string). A final
//   byte that leaves nothing to emit gives one bare end marker.
//   cfg_* writes a register: 0 pattern bytes, 1 pattern length,
//   2 replacement bytes, 3 replacement length. Write only while idle.
//   Writing the pattern or its length drops the held bytes.
// Sequencing:
//   One input item gives 0..8 result items; a final byte that is not part of
//   a match goes through the flush step, and a final byte with nothing to
//   emit gives a bare end marker. The sequencer walks the window through one
//   shared prefix compare unit and moves one result per cycle while the
//   output register is free; s_tready is high only while the sequencer is
//   idle, so a new input item is taken only once the last one is through.
// Reset: clears the window count, the sequencer and the output register;
//   registers return to pattern length 1, empty replacement.
// Stalls: a held result waits in the output register; the sequencer pauses
//   until it is taken.
module stream_find_and_replace_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,   // run_last
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] string_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import sfr_pkg::*;

  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] rep_bytes;
  logic [3:0]  rep_len;

  win_t                 win, win_next;
  logic [3:0]           count, count_next;
  seq_state_t           state, state_next;
  logic [WIN_IDX_W-1:0] ridx, ridx_next;
  logic                 last_flag, last_flag_next;
  logic                 pend_valid, pend_valid_next;
  logic [7:0]           pend_byte, pend_byte_next;

  logic [3:0]  plen, rlen, base;
  cmp_status_t cmp;
  logic        free, push, prod;
  logic [7:0]  prod_byte;
  result_t     item;

  assign plen      = eff_pattern_len(pat_len);
  assign rlen      = eff_repl_len(rep_len);
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  sfr_prefix_unit u_cmp (
    .win     (win),
    .count   (count),
    .pattern (pat_bytes),
    .plen    (plen),
    .status  (cmp)
  );

  sfr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always_comb begin
    win_next        = win;
    count_next      = count;
    state_next      = state;
    ridx_next       = ridx;
    last_flag_next  = last_flag;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;
    prod            = 1'b0;
    prod_byte       = win[0];
    push            = 1'b0;
    item            = '0;
    base            = (count >= plen) ? 4'd0 : count;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          win_next[base[WIN_IDX_W-1:0]] = s_tdata;
          count_next     = base + 4'd1;
          last_flag_next = s_tlast;
          state_next     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmp.is_match) begin
          count_next = 4'd0;
          ridx_next  = '0;
          state_next = (rlen == 4'd0) ? ST_FINISH : ST_REPL;
        end else if ((count != 4'd0) && !cmp.is_prefix) begin
          prod = free;
        end else begin
          state_next = last_flag ? ST_FLUSH : ST_FINISH;
        end
      end
      ST_REPL: begin
        if (free) begin
          prod      = 1'b1;
          prod_byte = rep_bytes[8*ridx +: 8];
          ridx_next = ridx + 1'b1;
          if ({1'b0, ridx} == rlen - 4'd1) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FLUSH: begin
        if (count == 4'd0) begin
          state_next = ST_FINISH;
        end else begin
          prod = free;
        end
      end
      ST_FINISH: begin
        if (pend_valid || last_flag) begin
          if (free) begin
            push            = 1'b1;
            item.data       = pend_valid ? pend_byte : 8'd0;
            item.byte_valid = pend_valid;
            item.run_last   = 1'b1;
            item.string_end = last_flag;
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Window shift on an emitted window byte (mismatch or flush).
    if (prod && state != ST_REPL) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_next[i] = win[i+1];
      end
      count_next = count - 4'd1;
    end

    // One-deep holding slot so run_last is known when a result leaves.
    if (prod) begin
      if (pend_valid) begin
        push            = 1'b1;
        item.data       = pend_byte;
        item.byte_valid = 1'b1;
      end
      pend_valid_next = 1'b1;
      pend_byte_next  = prod_byte;
    end

    // Pattern writes drop the held bytes.
    if (cfg_valid && cfg_ready &&
        ((cfg_reg_t'(cfg_index) == CFG_PATTERN_BYTES) ||
         (cfg_reg_t'(cfg_index) == CFG_PATTERN_LENGTH))) begin
      count_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= 4'd0;
      pend_valid <= 1'b0;
      last_flag  <= 1'b0;
      ridx       <= '0;
      pat_bytes  <= 64'd0;
      pat_len    <= 4'd1;
      rep_bytes  <= 64'd0;
      rep_len    <= 4'd0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      last_flag  <= last_flag_next;
      ridx       <= ridx_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PATTERN_BYTES: begin
            pat_bytes <= cfg_data;
          end
          CFG_PATTERN_LENGTH: begin
            pat_len <= cfg_data[3:0];
          end
          CFG_REPLACEMENT_BYTES: begin
            rep_bytes <= cfg_data;
          end
          CFG_REPLACEMENT_LEN: begin
            rep_len <= cfg_data[3:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    win       <= win_next;
    pend_byte <= pend_byte_next;
  end

endmodule

@@ sv/sfr_port_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the find-and-replace block, bound to the top level.
// Depends on stream_find_and_replace_core ports only.
module sfr_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // End of string is always the last result of its item.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("string end without run last");

  // A bare marker only closes a string and carries zero data.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1] && (m_tdata == 8'd0)))
    else $error("bad bare end marker");

  // Nothing leaves right after reset.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Stalled item holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled item changed");

endmodule

bind stream_find_and_replace_core sfr_port_checker u_sfr_port_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

@@ tb/sv/tb_stream_find_and_replace_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stream_find_and_replace_core: a byte-level
// rewrite predictor, directed and random strings, random stalls on both sides.
// Depends on sfr_pkg and the stream_find_and_replace_core RTL.
module tb_stream_find_and_replace_core;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 16;
  localparam int HOLD_TICKS   = 300;
  localparam int RANDOM_ITEMS = 264;
  localparam int NUM_PHASES   = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  // predictor state
  logic [63:0] pat_text = 64'd0;
  logic [3:0]  pat_len_reg = 4'd1;
  logic [63:0] rep_text = 64'd0;
  logic [3:0]  rep_len_reg = 4'd0;
  logic [7:0]  held [WIN_DEPTH];
  int          held_count = 0;
  result_t     pending_out [$];

  bit      src_idle_on = 1'b1;
  bit      sink_idle_on = 1'b1;
  logic    hold_sink = 1'b0;
  int      sink_gap = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;
  result_t want;

  stream_find_and_replace_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // data_byte
    .s_tlast   (s_tlast),    // in_last
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // out_byte
    .m_tlast   (m_tlast),    // run_last
    .m_tuser   (m_tuser),    // [0] byte_valid, [1] string_end
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int clamp_len(input logic [3:0] len, input int lo, input int hi);
    if (len < lo) return lo;
    if (len > hi) return hi;
    return len;
  endfunction

  function automatic bit window_on_pattern(input int cnt);
    for (int i = 0; i < cnt; i++) begin
      if (held[i] != pat_text[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the output items one accepted input byte causes.
  task automatic rewrite_byte(input logic [7:0] b, input logic last);
    int      plen;
    int      rlen;
    int      cnt;
    bit      done;
    result_t outs [$];
    result_t r;
    plen = clamp_len(pat_len_reg, 1, MAX_PATTERN);
    rlen = clamp_len(rep_len_reg, 0, MAX_REPLACEMENT);
    cnt = held_count;
    if (cnt >= plen) cnt = 0;
    held[cnt] = b;
    cnt++;
    done = 1'b0;
    while (!done) begin
      if (cnt == plen && window_on_pattern(cnt)) begin
        for (int i = 0; i < rlen; i++) begin
          r = '{data: rep_text[8*i +: 8], byte_valid: 1'b1, run_last: 1'b0, string_end: 1'b0};
          if (outs.size() < 8) outs.push_back(r);
        end
        cnt = 0;
        done = 1'b1;
      end else if (cnt > 0 && !window_on_pattern(cnt)) begin
        r = '{data: held[0], byte_valid: 1'b1, run_last: 1'b0, string_end: 1'b0};
        if (outs.size() < 8) outs.push_back(r);
        for (int i = 1; i < cnt; i++) held[i-1] = held[i];
        cnt--;
      end else begin
        done = 1'b1;
      end
    end
    if (last) begin
      for (int i = 0; i < cnt; i++) begin
        r = '{data: held[i], byte_valid: 1'b1, run_last: 1'b0, string_end: 1'b0};
        if (outs.size() < 8) outs.push_back(r);
      end
      cnt = 0;
      if (outs.size() == 0) begin
        r = '{data: 8'h00, byte_valid: 1'b0, run_last: 1'b0, string_end: 1'b0};
        outs.push_back(r);
      end
      outs[outs.size()-1].string_end = 1'b1;
    end
    if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
    held_count = cnt;
    foreach (outs[i]) pending_out.push_back(outs[i]);
  endtask

  // Result side: checks each accepted item and drives m_tready with stalls.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_out.size() == 0) begin
        $error("unexpected result item: out_byte %02h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_out.pop_front();
        if (m_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
          mismatch_count++;
        end
        if (m_tuser[0] !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_tuser[0]);
          mismatch_count++;
        end
        if (m_tlast !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, m_tlast);
          mismatch_count++;
        end
        if (m_tuser[1] !== want.string_end) begin
          $error("string_end: expected %0b, got %0b", want.string_end, m_tuser[1]);
          mismatch_count++;
        end
      end
    end
    if (hold_sink) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Leaves s_tvalid high after the handshake; wait_drained lowers it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rewrite_byte(b, last);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$], input bit end_string);
    for (int i = 0; i < bytes.size(); i++) begin
      send_byte(bytes[i], end_string && (i == bytes.size() - 1));
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PATTERN_BYTES: begin
        pat_text = value;
        held_count = 0;
      end
      CFG_PATTERN_LENGTH: begin
        pat_len_reg = value[3:0];
        held_count = 0;
      end
      CFG_REPLACEMENT_BYTES: rep_text = value;
      CFG_REPLACEMENT_LEN: rep_len_reg = value[3:0];
      default: ;
    endcase
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                           input logic [63:0] rep, input logic [3:0] rlen);
    write_reg(CFG_PATTERN_BYTES, pat, 1'b1);
    write_reg(CFG_PATTERN_LENGTH, {60'd0, plen}, 1'b1);
    write_reg(CFG_REPLACEMENT_BYTES, rep, 1'b1);
    write_reg(CFG_REPLACEMENT_LEN, {60'd0, rlen}, 1'b0);
  endtask

  // Drops s_tvalid, waits for every expected item, then for a possibly
  // silent item to finish.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Reset values: single zero byte pattern, empty replacement deletes it.
  task automatic test_reset_defaults();
    send_bytes('{8'h41, 8'h00, 8'h42}, 1'b1);
    send_bytes('{8'h00}, 1'b1);
    send_bytes('{8'hFF}, 1'b1);
    wait_drained();
  endtask

  // Overlapping prefixes, a full match, and a partial prefix flushed at the end.
  task automatic test_basic_replace();
    configure(64'h636261, 4'd3, 64'h5958, 4'd2);
    send_bytes('{8'h61, 8'h61, 8'h62, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62}, 1'b1);
    wait_drained();
  endtask

  // Saturating lengths and zero pattern length.
  task automatic test_length_limits();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0807_0605_0403_0201, 4'd15);
    send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
    wait_drained();
    configure(64'h0, 4'd0, 64'hA5A5_5A5A_FF00_807F, 4'd8);
    send_bytes('{8'h00}, 1'b1);
    wait_drained();
  endtask

  // Pattern write drops held bytes; replacement write applies at once.
  task automatic test_mid_string_change();
    configure(64'h6261, 4'd2, 64'h5A, 4'd1);
    send_bytes('{8'h61}, 1'b0);
    wait_drained();
    write_reg(CFG_PATTERN_BYTES, 64'h6463, 1'b1);
    write_reg(CFG_REPLACEMENT_BYTES, 64'h51, 1'b0);
    send_bytes('{8'h63, 8'h64}, 1'b1);
    wait_drained();
  endtask

  // Sink holds off while each input expands to eight output items.
  task automatic test_backpressure();
    logic [7:0] bytes [$];
    configure(64'h2A, 4'd1, 64'h4847_4645_4443_4241, 4'd8);
    repeat (12) bytes.push_back(8'h2A);
    fork
      begin
        hold_sink <= 1'b1;
        repeat (HOLD_TICKS) @(posedge clk);
        hold_sink <= 1'b0;
      end
      send_bytes(bytes, 1'b1);
    join
    wait_drained();
  endtask

  function automatic logic [7:0] alphabet_byte();
    case ($urandom_range(0, 2))
      0: return 8'h61;
      1: return 8'h62;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Strings built mostly from pattern copies and prefixes, over several settings.
  task automatic test_random_strings();
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [7:0]  bytes [$];
    int          span;
    int          goal;
    int          sent;
    int          pick;
    int          cut;
    for (int p = 0; p < NUM_PHASES; p++) begin
      pat = 64'd0;
      for (int i = 0; i < 8; i++) pat[8*i +: 8] = alphabet_byte();
      if (p == 4) pat = 64'd0;
      if (p == 5) pat = '1;
      rep = {$urandom, $urandom};
      case (p)
        0: begin plen = 4'd8;  rlen = 4'd0;  end
        1: begin plen = 4'd1;  rlen = 4'd8;  end
        2: begin plen = 4'd0;  rlen = 4'd15; end
        3: begin plen = 4'd15; rlen = 4'd1;  end
        default: begin
          plen = 4'($urandom_range(1, 8));
          rlen = 4'($urandom_range(0, 8));
        end
      endcase
      configure(pat, plen, rep, rlen);
      span = clamp_len(plen, 1, MAX_PATTERN);
      src_idle_on  = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      goal = RANDOM_ITEMS / NUM_PHASES;
      sent = 0;
      while (sent < goal) begin
        bytes.delete();
        cut = $urandom_range(1, 24);
        if (cut > goal - sent) cut = goal - sent;
        while (bytes.size() < cut) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            for (int i = 0; i < span; i++) bytes.push_back(pat[8*i +: 8]);
          end else if (pick < 6 && span > 1) begin
            for (int i = 0; i < $urandom_range(1, span - 1); i++)
              bytes.push_back(pat[8*i +: 8]);
          end else if (pick < 9) begin
            bytes.push_back(alphabet_byte());
          end else begin
            bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        send_bytes(bytes, 1'b1);
        sent += bytes.size();
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_basic_replace();
    test_length_limits();
    test_mid_string_change();
    test_backpressure();
    test_random_strings();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
